FILE: rtl/core/circular_gap_interpolator_defines.svh
// Assertion helpers shared by the RTL files of the gap interpolator.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CIRCULAR_GAP_INTERPOLATOR_DEFINES_SVH
`define CIRCULAR_GAP_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication.
`define CGI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CGI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cgi_pkg.sv
package cgi_pkg;

  localparam int unsigned SLOTS       = 12;
  localparam int unsigned VALUE_WIDTH = 24;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned IDX_W       = $clog2(SLOTS);
  // A blended numerator is at most (SLOTS-1) times a value in magnitude.
  localparam int unsigned NUM_W       = VALUE_WIDTH + IDX_W;
  localparam int unsigned MAG_W       = NUM_W - 1;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned DIV_DIGITS  = (MAG_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned QUO_W       = DIV_DIGITS * DIGIT_W;
  localparam int unsigned DCNT_W      = $clog2(DIV_DIGITS + 1);
  localparam int unsigned LANES       = 2;

  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [SLOTS-1:0]              mask_t;
  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [NUM_W-1:0]       num_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_OUT
  } fsm_e;

  typedef struct packed {
    logic                   start;
    idx_t                   den;
    logic [LANES-1:0][NUM_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic                             done;
    logic [LANES-1:0][VALUE_WIDTH-1:0] quot;
  } div_rsp_t;

  // Forward distance around the ring from one slot to another.
  function automatic idx_t ring_dist(idx_t from, idx_t to);
    int d;
    d = int'(to) - int'(from);
    if (d < 0) begin
      d = d + int'(SLOTS);
    end
    return idx_t'(d);
  endfunction

  // Nearest filled slot after t, going up and wrapping.
  function automatic idx_t next_filled(mask_t m, idx_t t);
    int   j;
    logic found;
    idx_t r;
    r     = t;
    found = 1'b0;
    for (int i = 1; i <= int'(SLOTS); i++) begin
      j = int'(t) + i;
      if (j >= int'(SLOTS)) begin
        j = j - int'(SLOTS);
      end
      if (!found && m[j]) begin
        r     = idx_t'(j);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  // Nearest filled slot before t, going down and wrapping.
  function automatic idx_t prev_filled(mask_t m, idx_t t);
    int   j;
    logic found;
    idx_t r;
    r     = t;
    found = 1'b0;
    for (int i = 1; i <= int'(SLOTS); i++) begin
      j = int'(t) - i;
      if (j < 0) begin
        j = j + int'(SLOTS);
      end
      if (!found && m[j]) begin
        r     = idx_t'(j);
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/cgi_if.sv
interface cgi_in_if
  import cgi_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [SLOT_W-1:0]             slot;
  logic signed [VALUE_WIDTH-1:0] center_value;
  logic signed [VALUE_WIDTH-1:0] spread_value;

  modport source (output valid, operation, slot, center_value, spread_value, input ready);
  modport sink   (input valid, operation, slot, center_value, spread_value, output ready);
endinterface

interface cgi_out_if
  import cgi_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic [SLOT_W-1:0]             out_slot;
  logic signed [VALUE_WIDTH-1:0] out_center;
  logic signed [VALUE_WIDTH-1:0] out_spread;
  logic                          last;

  modport source (output valid, out_slot, out_center, out_spread, last, input ready);
  modport sink   (input valid, out_slot, out_center, out_spread, last, output ready);
endinterface

FILE: rtl/core/cgi_ram.sv
module cgi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/cgi_div.sv
`include "circular_gap_interpolator_defines.svh"

module cgi_div
  import cgi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  // Two lanes of a signed-by-small-unsigned divider, DIGIT_W quotient bits per cycle.
  logic [QUO_W-1:0]  quo_q [LANES];
  logic [QUO_W-1:0]  quo_d [LANES];
  logic [IDX_W-1:0]  rem_q [LANES];
  logic [IDX_W-1:0]  rem_d [LANES];
  logic              neg_q [LANES];
  logic              neg_d [LANES];
  idx_t              den_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DCNT_W-1:0] cnt_d;
  logic              done_q;
  logic              done_d;

  always_comb begin : div_step
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] mag;
    logic [QUO_W-1:0] quo_t;
    logic [IDX_W:0]   part;
    logic [IDX_W-1:0] rem_t;
    num   = '0;
    mag   = '0;
    quo_t = '0;
    part  = '0;
    rem_t = '0;
    for (int l = 0; l < int'(LANES); l++) begin
      quo_d[l] = quo_q[l];
      rem_d[l] = rem_q[l];
      neg_d[l] = neg_q[l];
      if (req_i.start) begin
        num      = req_i.num[l];
        neg_d[l] = num[NUM_W-1];
        mag      = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
        quo_d[l] = QUO_W'(mag[MAG_W-1:0]);
        rem_d[l] = '0;
      end else if (cnt_q != '0) begin
        quo_t = quo_q[l];
        rem_t = rem_q[l];
        for (int d = 0; d < int'(DIGIT_W); d++) begin
          part  = {rem_t, quo_t[QUO_W-1]};
          quo_t = {quo_t[QUO_W-2:0], 1'b0};
          if (part >= {1'b0, den_q}) begin
            part     = part - {1'b0, den_q};
            quo_t[0] = 1'b1;
          end
          rem_t = part[IDX_W-1:0];
        end
        quo_d[l] = quo_t;
        rem_d[l] = rem_t;
      end
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = done_q;
    if (req_i.start) begin
      cnt_d  = DCNT_W'(DIV_DIGITS);
      done_d = 1'b0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < int'(LANES); l++) begin
      quo_q[l] <= quo_d[l];
      rem_q[l] <= rem_d[l];
      neg_q[l] <= neg_d[l];
    end
    if (req_i.start) begin
      den_q <= req_i.den;
    end
  end

  // The quotient takes the numerator's sign, which truncates toward zero.
  always_comb begin : div_out
    logic [QUO_W-1:0] qs;
    qs = '0;
    rsp_o.done = done_q;
    for (int l = 0; l < int'(LANES); l++) begin
      qs = neg_q[l] ? (QUO_W'(0) - quo_q[l]) : quo_q[l];
      rsp_o.quot[l] = qs[VALUE_WIDTH-1:0];
    end
  end

  `CGI_ASSERT_IMP(a_div_start_idle, req_i.start, cnt_q == '0, "divider restarted while busy")
  `CGI_ASSERT_IMP(a_div_done_idle, done_q, cnt_q == '0, "divider done while still running")
  `CGI_ASSERT_IMP(a_div_rem_range, cnt_q != '0, rem_q[0] < den_q, "divider remainder too large")

endmodule

FILE: rtl/core/circular_gap_interpolator.sv
// Circular gap interpolator.
// Input channel in_i: an item with operation load writes center_value and
// spread_value into the given slot and marks it filled; a slot beyond the
// table is dropped. An item with operation finish fills the gaps between
// filled slots by linear interpolation (quotient truncated toward zero),
// sends all slots 0..SLOTS-1 on out_o, last set on the final one, and then
// clears the table.
// A load is accepted in the idle state. During a finish the input is held off
// (ready low) until the last slot has been taken. A slot that was loaded, or
// any slot when fewer than two are filled, is read and sent out (states RDA,
// RDB, OUT); an interpolated slot also passes through MUL, START and DIV, where
// the two-lane divider produces DIGIT_W quotient bits per cycle.
// The slot values live in one synchronous RAM; a flop mask marks filled slots,
// and a slot whose bit is clear reads as zero, so reset and the clear after a
// finish take effect at once, with no sweep. A stalled receiver simply holds
// the current result; the walk resumes when it is taken.
`include "circular_gap_interpolator_defines.svh"

module circular_gap_interpolator
  import cgi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  cgi_in_if.sink   in_i,
  cgi_out_if.source out_o
);

  localparam int unsigned WORD_W = LANES * VALUE_WIDTH;

  fsm_e   state_q, state_d;
  idx_t   t_q, t_d;
  mask_t  mask_q, mask_d;
  logic   direct_q;
  logic   rd_vld_q;
  idx_t   wa_q, wb_q, den_q;
  value_t a_q   [LANES];
  value_t res_q [LANES];
  num_t   pa_q  [LANES];
  num_t   pb_q  [LANES];

  logic        ram_we;
  idx_t        ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  idx_t        ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  value_t      rd_val [LANES];

  idx_t  s_prev, e_next, src;
  logic  multi, hit, direct;
  logic  in_acc, out_acc, is_last, slot_ok;

  div_req_t div_req;
  div_rsp_t div_rsp;

  cgi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cgi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Neighbors of the current slot in the ring of filled slots.
  assign s_prev  = prev_filled(mask_q, t_q);
  assign e_next  = next_filled(mask_q, t_q);
  assign multi   = |(mask_q & (mask_q - 1'b1));
  assign hit     = mask_q[t_q];
  assign direct  = hit || !multi;
  assign src     = hit ? t_q : e_next;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign is_last = (t_q == IDX_W'(SLOTS - 1));
  assign slot_ok = (in_i.slot < SLOT_W'(SLOTS));

  // Cleared slots read as zero.
  assign rd_val[0] = rd_vld_q ? ram_rdata[WORD_W-1:VALUE_WIDTH] : '0;
  assign rd_val[1] = rd_vld_q ? ram_rdata[VALUE_WIDTH-1:0] : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.operation == OP_FINISH)) begin
          state_d = ST_RDA;
        end
      end
      ST_RDA:   state_d = ST_RDB;
      ST_RDB:   state_d = direct_q ? ST_OUT : ST_MUL;
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          state_d = is_last ? ST_IDLE : ST_RDA;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = e_next;
    div_req.start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_we     = in_i.valid && (in_i.operation == OP_LOAD) && slot_ok;
      end
      ST_RDA:   ram_raddr = direct ? src : s_prev;
      ST_START: div_req.start = 1'b1;
      ST_OUT:   out_o.valid = 1'b1;
      default: begin
      end
    endcase
  end

  assign ram_waddr   = idx_t'(in_i.slot);
  assign ram_wdata   = {in_i.center_value, in_i.spread_value};
  assign div_req.den = den_q;
  assign div_req.num[0] = pa_q[0] + pb_q[0];
  assign div_req.num[1] = pa_q[1] + pb_q[1];

  always_comb begin
    mask_d = mask_q;
    t_d    = t_q;
    if (ram_we) begin
      mask_d[ram_waddr] = 1'b1;
    end
    if ((state_q == ST_OUT) && out_acc) begin
      if (is_last) begin
        mask_d = '0;
        t_d    = '0;
      end else begin
        t_d = t_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      t_q     <= '0;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= mask_q[ram_raddr];
    if (state_q == ST_RDA) begin
      direct_q <= direct;
      wa_q     <= ring_dist(t_q, e_next);
      wb_q     <= ring_dist(s_prev, t_q);
      den_q    <= ring_dist(s_prev, e_next);
    end
    for (int l = 0; l < int'(LANES); l++) begin
      if (state_q == ST_RDB) begin
        a_q[l] <= rd_val[l];
        if (direct_q) begin
          res_q[l] <= rd_val[l];
        end
      end
      if (state_q == ST_MUL) begin
        pa_q[l] <= num_t'(a_q[l]) * $signed({1'b0, wa_q});
        pb_q[l] <= num_t'(rd_val[l]) * $signed({1'b0, wb_q});
      end
      if ((state_q == ST_DIV) && div_rsp.done) begin
        res_q[l] <= div_rsp.quot[l];
      end
    end
  end

  assign out_o.out_slot   = SLOT_W'(t_q);
  assign out_o.out_center = res_q[0];
  assign out_o.out_spread = res_q[1];
  assign out_o.last       = is_last;

  `CGI_ASSERT_NXT(a_clear_after_last, out_acc && out_o.last, mask_q == '0, "mask kept after last slot")
  `CGI_ASSERT_IMP(a_one_at_a_time, in_i.ready, !out_o.valid, "input taken during a finish")
  `CGI_ASSERT_NXT(a_walk_order, out_acc && !out_o.last, t_q == $past(t_q) + 1'b1, "slot walk skipped")

endmodule

FILE: tb/circular_gap_interpolator_tb.sv
import cgi_pkg::*;

typedef struct packed {
  logic [SLOT_W-1:0] slot;
  value_t            center;
  value_t            spread;
  logic              last;
} slot_result_t;

class slot_scoreboard;
  value_t       center_mem [SLOTS];
  value_t       spread_mem [SLOTS];
  mask_t        loaded;
  slot_result_t slot_results [$];
  int           errors;
  int           n_loads;
  int           n_dropped;
  int           n_finishes;
  int           n_results;

  function new();
    for (int i = 0; i < int'(SLOTS); i++) begin
      center_mem[i] = '0;
      spread_mem[i] = '0;
    end
    loaded     = '0;
    errors     = 0;
    n_loads    = 0;
    n_dropped  = 0;
    n_finishes = 0;
    n_results  = 0;
  endfunction

  function int pending();
    return slot_results.size();
  endfunction

  // Updates the table on a load; on a finish, fills the gaps and queues all slots.
  function void note_item(op_e op, logic [SLOT_W-1:0] slot, value_t c, value_t s);
    longint       cen [SLOTS];
    longint       spr [SLOTS];
    int           count;
    int           first;
    int           e;
    int           g;
    int           t;
    slot_result_t r;
    if (op == OP_LOAD) begin
      if (int'(slot) < int'(SLOTS)) begin
        center_mem[slot] = c;
        spread_mem[slot] = s;
        loaded[slot]     = 1'b1;
        n_loads++;
      end else begin
        n_dropped++;
      end
      return;
    end
    n_finishes++;
    count = 0;
    first = -1;
    for (int i = 0; i < int'(SLOTS); i++) begin
      cen[i] = longint'(center_mem[i]);
      spr[i] = longint'(spread_mem[i]);
      if (loaded[i]) begin
        if (first < 0) begin
          first = i;
        end
        count++;
      end
    end
    if (count == 1) begin
      for (int i = 0; i < int'(SLOTS); i++) begin
        cen[i] = cen[first];
        spr[i] = spr[first];
      end
    end else if (count >= 2) begin
      for (int i = 0; i < int'(SLOTS); i++) begin
        if (loaded[i]) begin
          e = (i + 1) % int'(SLOTS);
          while (!loaded[e]) begin
            e = (e + 1) % int'(SLOTS);
          end
          g = (e > i) ? (e - i - 1) : (int'(SLOTS) - 1 - i + e);
          // Division of longint truncates toward zero, as the block does.
          for (int k = 1; k <= g; k++) begin
            t = (i + k) % int'(SLOTS);
            cen[t] = ((g - k + 1) * cen[i] + k * cen[e]) / (g + 1);
            spr[t] = ((g - k + 1) * spr[i] + k * spr[e]) / (g + 1);
          end
        end
      end
    end
    for (int i = 0; i < int'(SLOTS); i++) begin
      r.slot   = i[SLOT_W-1:0];
      r.center = value_t'(cen[i]);
      r.spread = value_t'(spr[i]);
      r.last   = (i == int'(SLOTS) - 1);
      slot_results = {slot_results, r};
      center_mem[i] = '0;
      spread_mem[i] = '0;
    end
    loaded = '0;
  endfunction

  function void check_result(logic [SLOT_W-1:0] slot, value_t c, value_t s, logic last);
    slot_result_t r;
    n_results++;
    if (slot_results.size() == 0) begin
      $error("unexpected result: out_slot %0d, out_center %0d, out_spread %0d, last %0b",
             slot, c, s, last);
      errors++;
      return;
    end
    r = slot_results.pop_front();
    if (slot !== r.slot) begin
      $error("out_slot: expected %0d, actual %0d", r.slot, slot);
      errors++;
    end
    if (c !== r.center) begin
      $error("out_center: expected %0d, actual %0d", r.center, c);
      errors++;
    end
    if (s !== r.spread) begin
      $error("out_spread: expected %0d, actual %0d", r.spread, s);
      errors++;
    end
    if (last !== r.last) begin
      $error("last: expected %0b, actual %0b", r.last, last);
      errors++;
    end
  endfunction
endclass

module circular_gap_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 280;
  localparam value_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic clk_i;
  logic rst_ni;
  logic tx_idle;
  logic rx_idle;
  int   stall_cycles;

  slot_scoreboard sb;

  cgi_in_if  in_bus ();
  cgi_out_if out_bus ();

  circular_gap_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  function automatic value_t draw_value();
    case ($urandom_range(0, 7))
      0:       return VMAX;
      1:       return VMIN;
      2:       return value_t'(int'($urandom_range(0, 200)) - 100);
      default: return value_t'($urandom);
    endcase
  endfunction

  // Holds valid across back-to-back items so it never drops and rises in one step.
  task automatic send_item(op_e op, logic [SLOT_W-1:0] slot, value_t c, value_t s);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.operation    <= op;
    in_bus.slot         <= slot;
    in_bus.center_value <= c;
    in_bus.spread_value <= s;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_item(op, slot, c, s);
  endtask

  task automatic load_slot(logic [SLOT_W-1:0] slot, value_t c, value_t s);
    send_item(OP_LOAD, slot, c, s);
  endtask

  task automatic finish_period();
    send_item(OP_FINISH, SLOT_W'($urandom), value_t'($urandom), value_t'($urandom));
  endtask

  // Receiver: a random stall before each result, with stretches of none.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    rx_idle       = 1'b1;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        rx_idle = ~rx_idle;
      end
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      sb.check_result(out_bus.out_slot, out_bus.out_center, out_bus.out_spread,
                      out_bus.last);
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[circular_gap_interpolator] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int s;
    int order [SLOTS];
    int tmp;
    int j;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    stall_cycles        = 0;
    tx_idle             = 1'b1;
    in_bus.valid        = 1'b0;
    in_bus.operation    = OP_LOAD;
    in_bus.slot         = '0;
    in_bus.center_value = '0;
    in_bus.spread_value = '0;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty table, single filled slot at either end, overwrite,
    // out-of-range slots, extreme values across wrapping gaps, adjacent slots.
    finish_period();
    load_slot(0, VMAX, VMIN);
    finish_period();
    load_slot(11, VMIN, VMAX);
    finish_period();
    load_slot(3, 100, -100);
    load_slot(3, -5000, 7777);
    load_slot(12, VMAX, VMAX);
    load_slot(15, VMIN, VMIN);
    load_slot(8, VMAX, VMIN);
    finish_period();
    load_slot(0, VMIN, VMAX);
    load_slot(1, VMAX, VMIN);
    finish_period();
    load_slot(11, VMAX, -1);
    load_slot(0, VMIN, 1);
    load_slot(6, -1, VMIN);
    finish_period();
    finish_period();

    // Random periods: loads with random content, a few dropped, then a finish.
    while (sb.n_loads + sb.n_dropped + sb.n_finishes < ITEM_TARGET) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        for (int i = 0; i < int'(SLOTS); i++) begin
          order[i] = i;
        end
        for (int i = int'(SLOTS) - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < int'(SLOTS); i++) begin
          load_slot(SLOT_W'(order[i]), draw_value(), draw_value());
        end
      end else begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 14) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          s = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
          load_slot(SLOT_W'(s), draw_value(), draw_value());
        end
      end
      finish_period();
    end

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);

    $display("Ran %0d loads (%0d out-of-range dropped) and %0d finishes; checked %0d slots.",
             sb.n_loads, sb.n_dropped, sb.n_finishes, sb.n_results);
    if (sb.errors == 0) begin
      $display("[circular_gap_interpolator] OK");
    end else begin
      $display("[circular_gap_interpolator] ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/cgi_pkg.sv
rtl/core/cgi_if.sv
rtl/core/cgi_ram.sv
rtl/core/cgi_div.sv
rtl/core/circular_gap_interpolator.sv
tb/circular_gap_interpolator_tb.sv
